// ----- hw/rtl/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`default_nettype none

package u8u16_pkg;

    localparam int BYTE_W   = 8;
    localparam int UNIT_W   = 21;
    localparam int ACC_W    = 31;
    localparam int REM_W    = 3;
    localparam int CONT_W   = 6;
    localparam int SURR_W   = 10;
    localparam int NUM_W    = 2;
    localparam int FIFO_CNT_W = 2;

    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'b1100_0000;
    localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'b1110_0000;
    localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'b1111_0000;
    localparam logic [BYTE_W-1:0] LEAD5_MIN  = 8'b1111_1000;
    localparam logic [BYTE_W-1:0] LEAD6_MIN  = 8'b1111_1100;

    localparam logic [ACC_W-1:0]  PAIR_BASE  = 31'h0001_0000;
    localparam logic [UNIT_W-1:0] HI_SURR    = 21'h00D800;
    localparam logic [UNIT_W-1:0] LO_SURR    = 21'h00DC00;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              last_unit;
    } u8u16_unit_t;

    // units produced by one accepted byte: num is 0, 1 or 2
    typedef struct packed {
        logic [NUM_W-1:0] num;
        u8u16_unit_t      unit0;
        u8u16_unit_t      unit1;
    } u8u16_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/u8u16_decode.sv -----
// Byte decoder: accumulator state and code point to UTF-16 unit split.
`default_nettype none

module u8u16_decode
    import u8u16_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_fire,
    input  wire logic [BYTE_W-1:0] byte_in,
    output u8u16_res_t             res
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0] acc_sh;
    logic [REM_W-1:0] rem_dec;
    logic [ACC_W-1:0] cp;
    logic [ACC_W-1:0] cp_off;
    logic             emit;

    assign acc_sh  = {acc_reg[ACC_W-CONT_W-1:0], byte_in[CONT_W-1:0]};
    assign rem_dec = rem_reg - REM_W'(1);
    assign cp_off  = cp - PAIR_BASE;

    always_comb begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        cp       = '0;
        emit     = 1'b0;
        if (rem_reg != '0) begin
            rem_next = rem_dec;
            if (rem_dec == '0) begin
                cp       = acc_sh;
                emit     = 1'b1;
                acc_next = '0;
            end else begin
                acc_next = acc_sh;
            end
        end else if (byte_in == END_BYTE) begin
            emit = 1'b0;
        end else if (byte_in < LEAD2_MIN) begin
            cp   = ACC_W'(byte_in);
            emit = 1'b1;
        end else if (byte_in < LEAD3_MIN) begin
            acc_next = ACC_W'(byte_in[4:0]);
            rem_next = REM_W'(1);
        end else if (byte_in < LEAD4_MIN) begin
            acc_next = ACC_W'(byte_in[3:0]);
            rem_next = REM_W'(2);
        end else if (byte_in < LEAD5_MIN) begin
            acc_next = ACC_W'(byte_in[2:0]);
            rem_next = REM_W'(3);
        end else if (byte_in < LEAD6_MIN) begin
            acc_next = ACC_W'(byte_in[1:0]);
            rem_next = REM_W'(4);
        end else begin
            acc_next = ACC_W'(byte_in[0]);
            rem_next = REM_W'(5);
        end
    end

    always_comb begin
        res = '0;
        if (in_fire && emit) begin
            if (cp < PAIR_BASE) begin
                res.num             = NUM_W'(1);
                res.unit0.code_unit = cp[UNIT_W-1:0];
                res.unit0.last_unit = 1'b1;
            end else begin
                res.num             = NUM_W'(2);
                res.unit0.code_unit = HI_SURR | cp_off[ACC_W-1:SURR_W];
                res.unit0.last_unit = 1'b0;
                res.unit1.code_unit = LO_SURR | UNIT_W'(cp_off[SURR_W-1:0]);
                res.unit1.last_unit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            rem_reg <= '0;
        end else if (in_fire) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/u8u16_out_fifo.sv -----
// Three-entry result queue: takes up to two units per cycle, emits one per cycle while m_ready is high.
`default_nettype none

module u8u16_out_fifo
    import u8u16_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire u8u16_res_t        res,
    output logic                   room,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [UNIT_W-1:0]      m_code_unit,
    output logic                   m_last_unit
);

    u8u16_unit_t            q0_reg, q1_reg, q2_reg;
    u8u16_unit_t            q0_next, q1_next, q2_next;
    u8u16_unit_t            sh0, sh1, sh2;
    logic [FIFO_CNT_W-1:0]  cnt_reg, cnt_next, cnt_after;
    logic                   pop;

    assign m_valid     = (cnt_reg != '0);
    assign pop         = m_valid && m_ready;
    assign room        = (cnt_reg <= FIFO_CNT_W'(1));
    assign m_code_unit = q0_reg.code_unit;
    assign m_last_unit = q0_reg.last_unit;

    assign sh0       = pop ? q1_reg : q0_reg;
    assign sh1       = pop ? q2_reg : q1_reg;
    assign sh2       = q2_reg;
    assign cnt_after = cnt_reg - FIFO_CNT_W'(pop);

    always_comb begin
        q0_next  = sh0;
        q1_next  = sh1;
        q2_next  = sh2;
        cnt_next = cnt_after + FIFO_CNT_W'(res.num);
        if (res.num != '0) begin
            case (cnt_after)
                2'd0: begin
                    q0_next = res.unit0;
                    q1_next = res.unit1;
                end
                2'd1: begin
                    q1_next = res.unit0;
                    q2_next = res.unit1;
                end
                default: begin
                    q2_next = res.unit0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
        q2_reg <= q2_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_to_utf16_decoder.sv -----
// Top level of the UTF-8 to UTF-16 decoder.
//
// Input channel s_*: one UTF-8 byte per item (s_byte_in). Output channel
// m_*: one UTF-16 unit per item (m_code_unit, 21 bits) with m_last_unit
// high on the final unit of a code point. Code points at or above 0x10000
// leave as a high/low surrogate pair; a zero lead byte ends a string and
// produces nothing. No validation is done on the byte stream.
// The unit(s) for an accepted byte are registered in the output queue.
// Throughput: one byte per cycle while s_ready is high; the decode state sits in
// the accumulator registers and each byte updates it in a single pass. Output
// drains one unit per cycle, while m_ready is high, from a three-entry queue;
// s_ready is high while the queue holds at most one unit, so a surrogate pair
// can bring s_ready low even when m_ready stays high.
// Stall: with m_ready low, m_valid and the payload hold; the queue keeps
// taking bytes until two or more units are waiting, then s_ready falls.
// Reset (aresetn low, synchronous): accumulator, pending byte count and
// queue are cleared; s_ready is high and m_valid low right after.
`default_nettype none

module utf8_to_utf16_decoder
    import u8u16_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_byte_in,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [UNIT_W-1:0]      m_code_unit,
    output logic                   m_last_unit
);

    u8u16_res_t res;
    logic       in_fire;

    assign in_fire = s_valid && s_ready;

    u8u16_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .byte_in (s_byte_in),
        .res     (res)
    );

    u8u16_out_fifo u_out_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .res         (res),
        .room        (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_unit (m_code_unit),
        .m_last_unit (m_last_unit)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/u8u16_checker.sv -----
// Port-level assertions for the decoder, bound to the top level.
`default_nettype none

module u8u16_checker
    import u8u16_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_ready,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [UNIT_W-1:0] m_code_unit,
    input  wire logic              m_last_unit
);

    // stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_unit) && $stable(m_last_unit))
        else $error("output item changed while stalled");

    // low surrogate is queued together with the high one
    a_pair_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_unit |=> m_valid)
        else $error("low surrogate missing after high surrogate");

    // a high surrogate always carries the 0xD800 marker bits
    a_hi_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_unit |->
            m_code_unit[15] && m_code_unit[14] && m_code_unit[12] && m_code_unit[11])
        else $error("high surrogate without marker bits");

    // empty and ready right after reset
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("queue not empty after reset");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_u8u16_checker (.*);

`default_nettype wire
